// File: sv/tun_pkg.sv
// Package for the triangle unit-normal pipeline.
// Holds the parameter defaults and the lane count that the modules share.
package tun_pkg;

  parameter int unsigned COORD_BITS_DEF       = 16;
  parameter int unsigned NORMAL_FRAC_BITS_DEF = 14;
  parameter int unsigned NLANES               = 3;

endpackage

// File: sv/tun_cross.sv
// Edge vectors and cross product, three register stages.
// Depends on tun_pkg.
module tun_cross #(
  parameter int unsigned CB = tun_pkg::COORD_BITS_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              vld_i,
  input  logic signed [CB-1:0]                              p0_x_i,
  input  logic signed [CB-1:0]                              p0_y_i,
  input  logic signed [CB-1:0]                              p0_z_i,
  input  logic signed [CB-1:0]                              p1_x_i,
  input  logic signed [CB-1:0]                              p1_y_i,
  input  logic signed [CB-1:0]                              p1_z_i,
  input  logic signed [CB-1:0]                              p2_x_i,
  input  logic signed [CB-1:0]                              p2_y_i,
  input  logic signed [CB-1:0]                              p2_z_i,
  output logic                                              vld_o,
  output logic [tun_pkg::NLANES-1:0][2*(CB+1)-1:0]          mag_o,
  output logic [tun_pkg::NLANES-1:0]                        neg_o
);
  import tun_pkg::*;

  localparam int unsigned D  = CB + 1;
  localparam int unsigned P  = 2 * D;
  localparam int unsigned NW = P + 1;

  logic [2:0] v_q;
  logic signed [D-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [P-1:0] p_aybz_q, p_azby_q, p_azbx_q, p_axbz_q, p_aybx_q, p_axby_q;
  logic signed [NW-1:0] n_d [NLANES];
  logic [NLANES-1:0][P-1:0] mag_q;
  logic [NLANES-1:0]        neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], vld_i};
    end
  end

  // z component negated: ay*bx - ax*by
  always_comb begin
    n_d[0] = {p_aybz_q[P-1], p_aybz_q} - {p_azby_q[P-1], p_azby_q};
    n_d[1] = {p_azbx_q[P-1], p_azbx_q} - {p_axbz_q[P-1], p_axbz_q};
    n_d[2] = {p_aybx_q[P-1], p_aybx_q} - {p_axby_q[P-1], p_axby_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= {p0_x_i[CB-1], p0_x_i} - {p1_x_i[CB-1], p1_x_i};
      ay_q <= {p0_y_i[CB-1], p0_y_i} - {p1_y_i[CB-1], p1_y_i};
      az_q <= {p0_z_i[CB-1], p0_z_i} - {p1_z_i[CB-1], p1_z_i};
      bx_q <= {p1_x_i[CB-1], p1_x_i} - {p2_x_i[CB-1], p2_x_i};
      by_q <= {p1_y_i[CB-1], p1_y_i} - {p2_y_i[CB-1], p2_y_i};
      bz_q <= {p1_z_i[CB-1], p1_z_i} - {p2_z_i[CB-1], p2_z_i};
      p_aybz_q <= ay_q * bz_q;
      p_azby_q <= az_q * by_q;
      p_azbx_q <= az_q * bx_q;
      p_axbz_q <= ax_q * bz_q;
      p_aybx_q <= ay_q * bx_q;
      p_axby_q <= ax_q * by_q;
      for (int i = 0; i < NLANES; i++) begin
        neg_q[i] <= n_d[i][NW-1];
        mag_q[i] <= n_d[i][NW-1] ? P'(-n_d[i]) : P'(n_d[i]);
      end
    end
  end

  assign vld_o = v_q[2];
  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// File: sv/tun_sqsum.sv
// Squared length of the cross product, split squares over two stages.
// Depends on tun_pkg.
module tun_sqsum #(
  parameter int unsigned MW = 34
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [tun_pkg::NLANES-1:0][MW-1:0]  mag_i,
  input  logic [tun_pkg::NLANES-1:0]          neg_i,
  output logic                                vld_o,
  output logic [2*MW+1:0]                     sum_o,
  output logic [tun_pkg::NLANES-1:0][MW-1:0]  mag_o,
  output logic [tun_pkg::NLANES-1:0]          neg_o
);
  import tun_pkg::*;

  localparam int unsigned H  = (MW + 1) / 2;
  localparam int unsigned HH = MW - H;
  localparam int unsigned SW = 2 * MW + 2;

  logic [1:0] v_q;
  logic [NLANES-1:0][2*H-1:0]  pll_q;
  logic [NLANES-1:0][MW-1:0]   plh_q;
  logic [NLANES-1:0][2*HH-1:0] phh_q;
  logic [NLANES-1:0][MW-1:0]   mag1_q, mag2_q;
  logic [NLANES-1:0]           neg1_q, neg2_q;
  logic [SW-1:0] sq_d [NLANES];
  logic [SW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], vld_i};
    end
  end

  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      sq_d[i] = (SW'(phh_q[i]) << (2 * H)) + (SW'(plh_q[i]) << (H + 1)) + SW'(pll_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NLANES; i++) begin
        pll_q[i] <= (2*H)'(mag_i[i][H-1:0]) * (2*H)'(mag_i[i][H-1:0]);
        plh_q[i] <= MW'(mag_i[i][H-1:0]) * MW'(mag_i[i][MW-1:H]);
        phh_q[i] <= (2*HH)'(mag_i[i][MW-1:H]) * (2*HH)'(mag_i[i][MW-1:H]);
      end
      mag1_q <= mag_i;
      neg1_q <= neg_i;
      sum_q  <= sq_d[0] + sq_d[1] + sq_d[2];
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
    end
  end

  assign vld_o = v_q[1];
  assign sum_o = sum_q;
  assign mag_o = mag2_q;
  assign neg_o = neg2_q;

endmodule

// File: sv/tun_isqrt.sv
// Pipelined integer square root, one root bit per stage, shift-add only.
// Depends on tun_pkg; the side data rides along as an opaque tag.
module tun_isqrt #(
  parameter int unsigned SW = 70,
  parameter int unsigned TW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [SW-1:0]     sum_i,
  input  logic [TW-1:0]     tag_i,
  output logic              vld_o,
  output logic [SW/2-1:0]   root_o,
  output logic [TW-1:0]     tag_o
);
  import tun_pkg::*;

  localparam int unsigned RW = SW / 2;

  logic [RW-1:0] v_q;
  logic [SW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [TW-1:0] tag_q  [RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RW-2:0], vld_i};
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = RW - 1 - k;
    logic [SW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [TW-1:0] tag_in;
    logic [SW:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ((SW+1)'(root_in) << (B + 1)) + ((SW+1)'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k] <= tag_in;
        if (trial <= {1'b0, rem_in}) begin
          rem_q[k]  <= SW'({1'b0, rem_in} - trial);
          root_q[k] <= root_in | (RW'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign vld_o  = v_q[RW-1];
  assign root_o = root_q[RW-1];
  assign tag_o  = tag_q[RW-1];

endmodule

// File: sv/tun_div.sv
// Three-lane pipelined restoring divider: q = floor(m * 2^F / len), m <= len.
// Depends on tun_pkg; one quotient bit per stage, F+1 stages.
module tun_div #(
  parameter int unsigned MW = 34,
  parameter int unsigned F  = 14,
  parameter int unsigned TW = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [tun_pkg::NLANES-1:0][MW-1:0]  mag_i,
  input  logic [MW:0]                         len_i,
  input  logic [TW-1:0]                       tag_i,
  output logic                                vld_o,
  output logic [tun_pkg::NLANES-1:0][F:0]     quo_o,
  output logic [TW-1:0]                       tag_o
);
  import tun_pkg::*;

  localparam int unsigned LW = MW + 1;
  localparam int unsigned NS = F + 1;

  logic [NS-1:0] v_q;
  logic [NLANES-1:0][LW:0] r_q [NS];
  logic [NLANES-1:0][F:0]  q_q [NS];
  logic [LW-1:0]           len_q [NS];
  logic [TW-1:0]           tag_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], vld_i};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [NLANES-1:0][LW:0] r_in;
    logic [NLANES-1:0][F:0]  q_in;
    logic [LW-1:0]           len_in;
    logic [TW-1:0]           tag_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < NLANES; i++) begin
          r_in[i] = (LW+1)'(mag_i[i]);
          q_in[i] = '0;
        end
      end
      assign len_in = len_i;
      assign tag_in = tag_i;
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < NLANES; i++) begin
          r_in[i] = r_q[k-1][i] << 1;
          q_in[i] = q_q[k-1][i] << 1;
        end
      end
      assign len_in = len_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k] <= len_in;
        tag_q[k] <= tag_in;
        for (int i = 0; i < NLANES; i++) begin
          if (r_in[i] >= {1'b0, len_in}) begin
            r_q[k][i] <= r_in[i] - {1'b0, len_in};
            q_q[k][i] <= q_in[i] | (F+1)'(1);
          end else begin
            r_q[k][i] <= r_in[i];
            q_q[k][i] <= q_in[i];
          end
        end
      end
    end
  end

  assign vld_o = v_q[NS-1];
  assign quo_o = q_q[NS-1];
  assign tag_o = tag_q[NS-1];

endmodule

// File: sv/triangle_unit_normal.sv
// Stages in order: cross product, squares, square root, divide, output register.
// Throughput: one triangle per cycle; the pipeline holds one item per stage and
//   all stages advance together whenever the output register is empty or taken.
// Reset: rst_ni clears every valid bit at once; data registers are not reset.
// Depends on tun_pkg, tun_cross, tun_sqsum, tun_isqrt, tun_div.
module triangle_unit_normal #(
  parameter int unsigned COORD_BITS       = tun_pkg::COORD_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [COORD_BITS-1:0]       p0_x_i,
  input  logic signed [COORD_BITS-1:0]       p0_y_i,
  input  logic signed [COORD_BITS-1:0]       p0_z_i,
  input  logic signed [COORD_BITS-1:0]       p1_x_i,
  input  logic signed [COORD_BITS-1:0]       p1_y_i,
  input  logic signed [COORD_BITS-1:0]       p1_z_i,
  input  logic signed [COORD_BITS-1:0]       p2_x_i,
  input  logic signed [COORD_BITS-1:0]       p2_y_i,
  input  logic signed [COORD_BITS-1:0]       p2_z_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  output logic                               degenerate_o
);
  import tun_pkg::*;

  localparam int unsigned MW  = 2 * (COORD_BITS + 1);   // |n| magnitude width
  localparam int unsigned SW  = 2 * MW + 2;             // squared length width
  localparam int unsigned RW  = SW / 2;                 // root width
  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned OW  = F + 2;
  localparam int unsigned TWS = 1 + NLANES + NLANES * MW;   // root-stage side data
  localparam int unsigned TWD = 1 + NLANES;                 // divide-stage side data

  // Global advance: everything moves when the output slot is free or drained.
  logic en;
  assign en      = !valid_o || !stall_i;
  assign stall_o = !en;

  // Cross product
  logic                         cr_vld;
  logic [NLANES-1:0][MW-1:0]    cr_mag;
  logic [NLANES-1:0]            cr_neg;

  tun_cross #(.CB(COORD_BITS)) u_cross (
    .clk_i, .rst_ni, .en_i(en), .vld_i(valid_i),
    .p0_x_i, .p0_y_i, .p0_z_i, .p1_x_i, .p1_y_i, .p1_z_i,
    .p2_x_i, .p2_y_i, .p2_z_i,
    .vld_o(cr_vld), .mag_o(cr_mag), .neg_o(cr_neg)
  );

  // Squared length
  logic                         sq_vld;
  logic [SW-1:0]                sq_sum;
  logic [NLANES-1:0][MW-1:0]    sq_mag;
  logic [NLANES-1:0]            sq_neg;

  tun_sqsum #(.MW(MW)) u_sqsum (
    .clk_i, .rst_ni, .en_i(en), .vld_i(cr_vld), .mag_i(cr_mag), .neg_i(cr_neg),
    .vld_o(sq_vld), .sum_o(sq_sum), .mag_o(sq_mag), .neg_o(sq_neg)
  );

  // Square root; a zero sum marks the triangle as degenerate
  logic                         rt_vld;
  logic [RW-1:0]                rt_root;
  logic [TWS-1:0]               rt_tag_in, rt_tag;
  logic [NLANES-1:0][MW-1:0]    rt_mag;
  logic [NLANES-1:0]            rt_neg;
  logic                         rt_deg;
  logic [RW-1:0]                rt_len;

  assign rt_tag_in = {(sq_sum == '0), sq_neg, sq_mag};

  tun_isqrt #(.SW(SW), .TW(TWS)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(sq_vld), .sum_i(sq_sum), .tag_i(rt_tag_in),
    .vld_o(rt_vld), .root_o(rt_root), .tag_o(rt_tag)
  );

  assign {rt_deg, rt_neg, rt_mag} = rt_tag;
  // zero length: divide by one, magnitudes are all zero anyway
  assign rt_len = (rt_root == '0) ? RW'(1) : rt_root;

  // Scaled division
  logic                         dv_vld;
  logic [NLANES-1:0][F:0]       dv_quo;
  logic [TWD-1:0]               dv_tag;
  logic                         dv_deg;
  logic [NLANES-1:0]            dv_neg;

  tun_div #(.MW(MW), .F(F), .TW(TWD)) u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(rt_vld), .mag_i(rt_mag), .len_i(rt_len),
    .tag_i({rt_deg, rt_neg}),
    .vld_o(dv_vld), .quo_o(dv_quo), .tag_o(dv_tag)
  );

  assign {dv_deg, dv_neg} = dv_tag;

  // Output register: sign restored, Q1.F
  logic                 out_vld_q;
  logic [OW-1:0]        nrm_q [NLANES];
  logic                 deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q <= dv_deg;
      for (int i = 0; i < NLANES; i++) begin
        nrm_q[i] <= dv_neg[i] ? OW'(-OW'(dv_quo[i])) : OW'(dv_quo[i]);
      end
    end
  end

  assign valid_o      = out_vld_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = deg_q;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero normal");

  a_nondeg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !degenerate_o |-> normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
    else $error("zero normal without degenerate flag");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> normal_x_o <= $signed(OW'(1) << F) && normal_x_o >= -$signed(OW'(1) << F)
             && normal_z_o <= $signed(OW'(1) << F) && normal_z_o >= -$signed(OW'(1) << F))
    else $error("normal component outside unit range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(normal_y_o) && $stable(degenerate_o))
    else $error("output changed while pipeline held");
`endif

endmodule

// File: dv/triangle_unit_normal_tb.sv
// Self-checking testbench for triangle_unit_normal: drives triangles, predicts
// each unit normal in fixed point and compares it with the block's transfers.
// Depends on tun_pkg and the triangle_unit_normal RTL.
`timescale 1ns / 1ps

module triangle_unit_normal_tb;

  localparam int CW = tun_pkg::COORD_BITS_DEF;
  localparam int FB = tun_pkg::NORMAL_FRAC_BITS_DEF;
  localparam int NW = FB + 2;
  localparam int LATENCY = 56;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1150;
  localparam int QUIET_TAIL = 150;  // last transfers run without idling

  typedef struct {
    logic signed [CW-1:0] c[9];  // p0 xyz, p1 xyz, p2 xyz
  } tri_t;

  typedef struct {
    logic signed [NW-1:0] nx, ny, nz;
    logic                 degen;
  } normal_t;

  logic clk_i, rst_ni;
  logic valid_i, stall_o, valid_o, stall_i;
  logic signed [CW-1:0] p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i;
  logic signed [CW-1:0] p2_x_i, p2_y_i, p2_z_i;
  logic signed [NW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;

  triangle_unit_normal dut (.*);

  tri_t    pending_tris[$];
  normal_t expected_normals[$];
  int      mismatches = 0;
  int      sent_count = 0;
  int      total_tris = 0;
  bit      stim_done = 0;
  int      idle_cycles = 0;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Floor square root of a sum of squares, up to 2*(2*CW+2)+2 bits.
  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [63:0] root;
    logic [63:0] cand;
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= s) root = cand;
    end
    return root;
  endfunction

  function automatic normal_t predict_normal(tri_t t);
    longint ax, ay, az, bx, by, bz;
    longint n[3];
    logic [127:0] sq;
    logic [63:0] len, mg, q;
    normal_t r;
    ax = longint'(t.c[0]) - longint'(t.c[3]);
    ay = longint'(t.c[1]) - longint'(t.c[4]);
    az = longint'(t.c[2]) - longint'(t.c[5]);
    bx = longint'(t.c[3]) - longint'(t.c[6]);
    by = longint'(t.c[4]) - longint'(t.c[7]);
    bz = longint'(t.c[5]) - longint'(t.c[8]);
    n[0] = ay * bz - az * by;
    n[1] = az * bx - ax * bz;
    n[2] = ay * bx - ax * by;  // negated z
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mg = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
      sq += 128'(mg) * 128'(mg);
    end
    if (sq == 0) begin
      r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1;
      return r;
    end
    len = floor_sqrt(sq);
    if (len == 0) len = 1;
    r.degen = 0;
    for (int i = 0; i < 3; i++) begin
      mg = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
      // |n| <= len so the quotient is at most 2^FB and fits in NW bits
      q = 64'((128'(mg) << FB) / 128'(len));
      if (n[i] < 0) q = -q;
      case (i)
        0: r.nx = q[NW-1:0];
        1: r.ny = q[NW-1:0];
        default: r.nz = q[NW-1:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return CW'(int'($urandom_range(0, 15)) - 8);  // short vectors
      default: return CW'($urandom);
    endcase
  endfunction

  // Stimulus: directed corner cases, then random triangles.
  initial begin
    tri_t t;
    logic signed [CW-1:0] ext[4];
    ext = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    // all-zero, coincident extremes
    foreach (ext[k]) begin
      foreach (t.c[i]) t.c[i] = ext[k];
      pending_tris = {pending_tris, t};
    end
    // collinear triangle
    t.c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    pending_tris = {pending_tris, t};
    // tiny cross products: n = (0,-1,1) and (0,0,-1)
    t.c = '{0, 0, 0, 1, 0, 0, 1, 1, 1};
    pending_tris = {pending_tris, t};
    t.c = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
    pending_tris = {pending_tris, t};
    // widest edges in every axis, random orientations
    for (int k = 0; k < 8; k++) begin
      foreach (t.c[i]) t.c[i] = ext[$urandom_range(0, 1)];
      t.c[k] = ~t.c[k];
      pending_tris = {pending_tris, t};
    end
    t.c = '{16'sh7FFF, 0, 0, 16'sh8000, 16'sh8000, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    pending_tris = {pending_tris, t};
    t.c = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
            16'sh8000, 16'sh8000, 16'sh7FFF};
    pending_tris = {pending_tris, t};
    for (int n = 0; n < N_RANDOM; n++) begin
      foreach (t.c[i]) t.c[i] = rand_coord();
      // some degenerate cases: repeat a vertex or make it collinear (unless 2*p1-p0 wraps)
      case ($urandom_range(0, 15))
        0: for (int i = 0; i < 3; i++) t.c[6+i] = t.c[3+i];
        1: for (int i = 0; i < 3; i++) t.c[3+i] = t.c[i];
        2: for (int i = 0; i < 3; i++) t.c[6+i] = CW'(2 * t.c[3+i] - t.c[i]);
        default: ;
      endcase
      pending_tris = {pending_tris, t};
    end
    total_tris = pending_tris.size();
  end

  // Idle bursts on either side, off for the tail of the run.
  int src_gap = 0, sink_stall = 0;
  wire quiet = (sent_count + QUIET_TAIL >= total_tris) && total_tris != 0;

  // Driver: valid_i and the payload hold while a triangle is offered and stall_o is high.
  always @(posedge clk_i or negedge rst_ni) begin
    tri_t t;
    if (!rst_ni) begin
      valid_i <= 0;
      {p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i, p2_x_i, p2_y_i, p2_z_i} <= '0;
    end else begin
      if (valid_i && !stall_o) begin
        t = pending_tris.pop_front();
        expected_normals = {expected_normals, predict_normal(t)};
        sent_count <= sent_count + 1;
      end
      if (!valid_i || !stall_o) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          valid_i <= 0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(1, 14) - 1;
          valid_i <= 0;
        end else if (pending_tris.size() > 0) begin
          t = pending_tris[0];
          valid_i <= 1;
          {p0_x_i, p0_y_i, p0_z_i} <= {t.c[0], t.c[1], t.c[2]};
          {p1_x_i, p1_y_i, p1_z_i} <= {t.c[3], t.c[4], t.c[5]};
          {p2_x_i, p2_y_i, p2_z_i} <= {t.c[6], t.c[7], t.c[8]};
        end else begin
          valid_i <= 0;
        end
      end
    end
  end

  // Monitor: compares each output transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    normal_t e;
    if (!rst_ni) begin
      stall_i <= 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output transfer");
        end else begin
          e = expected_normals.pop_front();
          if (normal_x_o !== e.nx || normal_y_o !== e.ny || normal_z_o !== e.nz
              || degenerate_o !== e.degen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp (%0d %0d %0d deg %0d) got (%0d %0d %0d deg %0d)",
                       e.nx, e.ny, e.nz, e.degen,
                       normal_x_o, normal_y_o, normal_z_o, degenerate_o);
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        stall_i <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_stall <= $urandom_range(1, 14) - 1;
        stall_i <= 1;
      end else begin
        stall_i <= 0;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    wait (total_tris != 0 && sent_count == total_tris && expected_normals.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: triangle_unit_normal.f
sv/tun_pkg.sv
sv/tun_cross.sv
sv/tun_sqsum.sv
sv/tun_isqrt.sv
sv/tun_div.sv
sv/triangle_unit_normal.sv
dv/triangle_unit_normal_tb.sv
